FILE: src/egcd_pkg.sv
// shared types for the extended gcd block: sequencer states and control/status bundles
package egcd_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALIGN,
		ST_SUB,
		ST_UPDATE,
		ST_DONE
	} state_t;

	// commands from the sequencer to the shared divide unit
	typedef struct packed {
		logic load;
		logic init_div;
		logic align_shift;
		logic sub_step;
		logic update;
	} ctrl_t;

	// flags from the divide unit back to the sequencer
	typedef struct packed {
		logic rem_zero;
		logic align_more;
	} status_t;

endpackage

FILE: src/egcd_in_if.sv
// operand channel: valid/ready handshake carrying the two operands
interface egcd_in_if #(
	parameter int DATA_WIDTH = 64
);
	logic                    valid;
	logic                    ready;
	logic [DATA_WIDTH-2:0]   operand_a;
	logic [DATA_WIDTH-2:0]   operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

FILE: src/egcd_out_if.sv
// result channel: valid/ready handshake carrying gcd and bezout coefficient
interface egcd_out_if #(
	parameter int DATA_WIDTH = 64
);
	logic                         valid;
	logic                         ready;
	logic [DATA_WIDTH-2:0]        divisor;
	logic signed [DATA_WIDTH-1:0] coefficient_b;

	modport source (output valid, output divisor, output coefficient_b, input ready);
	modport sink (input valid, input divisor, input coefficient_b, output ready);
endinterface

FILE: src/egcd_divstep.sv
// shared shift-subtract divide unit with horner accumulation of quotient times coefficient
module egcd_divstep import egcd_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                    clk,
	input  ctrl_t                   ctrl,
	input  logic [DATA_WIDTH-2:0]   operand_a,
	input  logic [DATA_WIDTH-2:0]   operand_b,
	output status_t                 status,
	output logic [DATA_WIDTH-2:0]   rem_prev,
	output logic [DATA_WIDTH-1:0]   coef_prev
);
	localparam int OW = DATA_WIDTH - 1;
	localparam int W  = DATA_WIDTH;

	logic [OW-1:0] rem_prev_q, rem_cur_q, rem_work_q;
	logic [W-1:0]  coef_prev_q, coef_cur_q, acc_q;
	logic [W-1:0]  div_sh_q;

	logic [W-1:0]  rem_ext;
	logic [W-1:0]  div_dbl;
	logic [W-1:0]  diff;
	logic          ge;
	logic [W-1:0]  acc_next;

	// compare and subtract against the aligned divisor
	assign rem_ext  = {1'b0, rem_work_q};
	assign div_dbl  = {div_sh_q[W-2:0], 1'b0};
	assign ge       = rem_ext >= div_sh_q;
	assign diff     = rem_ext - div_sh_q;
	assign acc_next = {acc_q[W-2:0], 1'b0} + (ge ? coef_cur_q : '0);

	assign status.rem_zero   = (rem_cur_q == '0);
	assign status.align_more = (div_dbl <= rem_ext);

	assign rem_prev  = rem_prev_q;
	assign coef_prev = coef_prev_q;

	// remainder and coefficient registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_prev_q  <= operand_a;
			rem_cur_q   <= operand_b;
			coef_prev_q <= '0;
			coef_cur_q  <= W'(1);
		end else if (ctrl.update) begin
			rem_prev_q  <= rem_cur_q;
			rem_cur_q   <= rem_work_q;
			coef_prev_q <= coef_cur_q;
			coef_cur_q  <= coef_prev_q - acc_q;
		end
	end

	// working remainder, shifted divisor and quotient-times-coefficient accumulator
	always_ff @(posedge clk) begin
		if (ctrl.init_div) begin
			rem_work_q <= rem_prev_q;
			div_sh_q   <= {1'b0, rem_cur_q};
			acc_q      <= '0;
		end else if (ctrl.align_shift) begin
			div_sh_q <= div_dbl;
		end else if (ctrl.sub_step) begin
			if (ge) begin
				rem_work_q <= diff[OW-1:0];
			end
			acc_q    <= acc_next;
			div_sh_q <= {1'b0, div_sh_q[W-1:1]};
		end
	end

endmodule

FILE: src/egcd_seq.sv
// sequencer: steps the shared divide unit through align, subtract and update phases
module egcd_seq import egcd_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_ready,
	input  status_t status,
	output logic    in_ready,
	output logic    out_valid,
	output ctrl_t   ctrl
);
	localparam int KW = $clog2(DATA_WIDTH);

	state_t        state_q, state_d;
	logic [KW-1:0] shift_q, shift_d;

	// state and shift count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			shift_q <= '0;
		end else begin
			state_q <= state_d;
			shift_q <= shift_d;
		end
	end

	// next state and unit commands
	always_comb begin
		state_d   = state_q;
		shift_d   = shift_q;
		ctrl      = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.rem_zero) begin
					state_d = ST_DONE;
				end else begin
					ctrl.init_div = 1'b1;
					shift_d       = '0;
					state_d       = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (status.align_more) begin
					ctrl.align_shift = 1'b1;
					shift_d          = shift_q + KW'(1);
				end else begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				ctrl.sub_step = 1'b1;
				if (shift_q == '0) begin
					state_d = ST_UPDATE;
				end else begin
					shift_d = shift_q - KW'(1);
				end
			end
			ST_UPDATE: begin
				ctrl.update = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: src/extended_gcd.sv
// extended gcd top level: sequencer plus shared shift-subtract divide unit
//
//   channel   | dir | words carried
//   ----------+-----+------------------------------------------
//   operands  | in  | operand_a, operand_b (DATA_WIDTH-1 bits)
//   result    | out | divisor, coefficient_b (two's complement)
//
// one word at a time: operands is ready only while the block is idle
// per division step: a check, then the align, subtract and update phases in that order;
//   plus an accept before the first step, a final check after the last step
//   and a result state
// the result word is held in the unit registers until the sink takes it
// asynchronous active-low reset returns the sequencer to idle; data registers are not reset
module extended_gcd import egcd_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	egcd_in_if.sink               operands,
	egcd_out_if.source            result
);
	ctrl_t                 ctrl;
	status_t               status;
	logic [DATA_WIDTH-2:0] rem_prev;
	logic [DATA_WIDTH-1:0] coef_prev;

	// sequencer
	egcd_seq #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.out_ready (result.ready),
		.status    (status),
		.in_ready  (operands.ready),
		.out_valid (result.valid),
		.ctrl      (ctrl)
	);

	// shared divide unit
	egcd_divstep #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_div (
		.clk       (clk),
		.ctrl      (ctrl),
		.operand_a (operands.operand_a),
		.operand_b (operands.operand_b),
		.status    (status),
		.rem_prev  (rem_prev),
		.coef_prev (coef_prev)
	);

	// result word straight from the unit registers
	assign result.divisor       = rem_prev;
	assign result.coefficient_b = $signed(coef_prev);

endmodule

FILE: src/egcd_checker.sv
// port-level checks on the extended gcd block, bound to the top level
module egcd_checker #(
	parameter int DATA_WIDTH = 64
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-2:0] divisor,
	input logic [DATA_WIDTH-1:0] coefficient_b
);
	// never idle and holding a result at once
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("operands ready while a result is pending");

	// an accepted word closes the operand side
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("operands still ready after accept");

	// no result in the cycle after accept: at least one check step
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("result shown directly after accept");

	// a taken result returns the block to idle
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> (in_ready && !out_valid))
		else $error("block not idle after result taken");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(divisor) && $stable(coefficient_b)))
		else $error("stalled result changed");

endmodule

bind extended_gcd egcd_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_egcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (operands.valid),
	.in_ready      (operands.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.divisor       (result.divisor),
	.coefficient_b (result.coefficient_b)
);
